// ----- rtl/core/ptfr_pkg.sv -----
`default_nettype none
package ptfr_pkg;
    localparam int MaxProcesses = 16;
    localparam int MaxPages     = 64;
    localparam int Frames       = 64;
    localparam int PidW         = 5;
    localparam int PageW        = 6;
    localparam int FrameW       = 6;
    localparam int SlotW        = 10;
    localparam int TimeW        = 32;

    localparam logic [1:0] StOk      = 2'd0;
    localparam logic [1:0] StUnknown = 2'd1;
    localparam logic [1:0] StRange   = 2'd2;
    localparam logic [1:0] StFull    = 2'd3;

    localparam logic       OpCreate    = 1'b0;
    localparam logic       OpTranslate = 1'b1;

    localparam logic       CfgPageSize   = 1'b0;
    localparam logic       CfgFrameCount = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [4:0]  process_id;
        logic [17:0] virtual_address;
        logic [18:0] process_size;
        logic [31:0] time_now;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] physical_address;
        logic        page_fault;
        logic [5:0]  frame_index;
        logic        evicted;
        logic [4:0]  new_process_id;
    } t_out;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input item
        logic div_start;  // start divide
        logic div_step;   // one quotient bit
        logic decide;     // evaluate checks
        logic lookup;     // read page table
        logic scan_step;  // one frame
        logic commit;     // write back
        logic out_load;   // load result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic div_done;
        logic is_create;
        logic fail;       // status not ok
        logic clr_done;   // page-present clear finished
        logic hit;
        logic scan_done;
    } t_sts;
endpackage
`default_nettype wire

// ----- rtl/core/ptfr_ctrl.sv -----
`default_nettype none
module ptfr_ctrl
    import ptfr_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    input  wire  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_DEC  = 3'd2;
    localparam logic [2:0] S_LOOK = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_CLR  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    // sequencing
    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid && !i_out_ready;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) n_state = S_DEC;
                else o_cmd.div_step = 1'b1;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                if (i_sts.fail) n_state = S_FIN;
                else if (i_sts.is_create) n_state = S_CLR;
                else n_state = S_LOOK;
            end
            S_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.hit || i_sts.scan_done) n_state = S_FIN;
                else o_cmd.scan_step = 1'b1;
            end
            S_CLR: begin
                if (i_sts.clr_done) n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.commit   = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_ovalid       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        o_cmd.div_start = o_cmd.load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_load_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> o_out_valid) else $error("result lost");
    a_commit_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> r_state == S_FIN) else $error("commit out of order");
endmodule
`default_nettype wire

// ----- rtl/core/ptfr_dp.sv -----
`default_nettype none
module ptfr_dp
    import ptfr_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_valid,
    input  wire        i_cfg_index,
    input  wire [12:0] i_cfg_data,
    input  wire  t_in  i_in,
    input  wire  t_cmd i_cmd,
    output t_sts       o_sts,
    output t_out       o_out
);
    // configuration
    logic [12:0] r_page_size;
    logic [6:0]  r_frame_count;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_size   <= 13'd256;
            r_frame_count <= 7'd64;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CfgPageSize) r_page_size <= i_cfg_data;
            else r_frame_count <= i_cfg_data[6:0];
        end
    end

    logic [12:0] ps_eff;
    logic [6:0]  nfr;
    assign ps_eff = (r_page_size == 13'd0) ? 13'd1 : r_page_size;
    assign nfr = (r_frame_count == 7'd0) ? 7'd1 :
                 (r_frame_count > 7'd64) ? 7'd64 : r_frame_count;

    // captured item
    t_in r_item;
    always_ff @(posedge i_clk) if (i_cmd.load) r_item <= i_in;

    // restoring divider, one quotient bit per cycle
    logic [18:0] r_quo;
    logic [13:0] r_rem;
    logic [4:0]  r_dcnt;
    logic [18:0] div_num;
    logic [13:0] rem_sh;
    logic [18:0] size_m1;
    assign size_m1 = i_in.process_size - 19'd1;
    assign rem_sh  = {r_rem[12:0], r_quo[18]};
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dcnt <= '0;
        else if (i_cmd.div_start) begin
            r_dcnt <= 5'd19;
            r_quo  <= (i_in.opcode == OpCreate) ? size_m1 : {1'b0, i_in.virtual_address};
            r_rem  <= '0;
        end else if (i_cmd.div_step) begin
            r_dcnt <= r_dcnt - 5'd1;
            if (rem_sh >= {1'b0, ps_eff}) begin
                r_rem <= rem_sh - {1'b0, ps_eff};
                r_quo <= {r_quo[17:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_quo <= {r_quo[17:0], 1'b0};
            end
        end
    end
    assign div_num = r_quo;
    assign o_sts.div_done = (r_dcnt == 5'd0);

    // process table
    logic [4:0] r_pcount;
    logic [6:0] r_ppc [MaxProcesses];
    logic [19:0] pages;     // ceil(size/ps) = (size-1)/ps + 1
    assign pages = {1'b0, div_num} + 20'd1;

    logic [3:0]  pidx;
    logic [17:0] page_q;
    assign pidx   = r_item.process_id[3:0] - 4'd1;
    assign page_q = div_num[17:0];

    logic [1:0]  r_status;
    logic [1:0]  st;
    always_comb begin
        st = StOk;
        if (r_item.opcode == OpCreate) begin
            if (r_pcount >= 5'd16) st = StFull;
            else if (r_item.process_size == 19'd0) st = StRange;
            else if (pages > 20'd64) st = StFull;
        end else begin
            if (r_item.process_id == 5'd0 || r_item.process_id > r_pcount) st = StUnknown;
            else if (page_q >= {11'd0, r_ppc[pidx]}) st = StRange;
        end
    end
    assign o_sts.is_create = (r_item.opcode == OpCreate);
    assign o_sts.fail      = (st != StOk);

    // page present bits and page frame memory
    logic [1023:0] r_present;
    logic [5:0]    r_pframe [1024];
    logic [9:0]    r_slot;
    logic [5:0]    r_lk_frame;
    logic          r_hit;
    logic [6:0]    r_clr;
    logic          r_clr_act;

    // frame table
    logic [63:0]   r_occ;
    logic [9:0]    r_owner [Frames];
    logic [31:0]   r_ltime [Frames];
    logic [6:0]    r_scan;
    logic [5:0]    r_best;
    logic [31:0]   r_best_time;
    logic          r_free;
    logic          r_sdone;
    logic          r_rd_end;
    logic          r_tq_v;
    logic          r_tq_last;
    logic [5:0]    r_tq_idx;
    logic [31:0]   r_tq;
    logic [9:0]    r_victim;
    logic [5:0]    si;
    logic          scan_rd;
    logic          scan_free;
    logic          frame_wr;
    assign si        = r_scan[5:0];
    assign scan_rd   = i_cmd.scan_step && !r_rd_end && r_occ[si];
    assign scan_free = i_cmd.scan_step && !r_rd_end && !r_occ[si];
    assign frame_wr  = i_cmd.commit && r_item.opcode == OpTranslate &&
                       r_status == StOk && !r_hit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) r_lk_frame <= r_pframe[r_slot];
        if (frame_wr) r_pframe[r_slot] <= r_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcount  <= '0;
            r_present <= '0;
            r_occ     <= '0;
            r_clr_act <= 1'b0;
            r_sdone   <= 1'b0;
            r_rd_end  <= 1'b0;
            r_tq_v    <= 1'b0;
        end else begin
            if (i_cmd.decide) begin
                r_status <= st;
                r_slot   <= {pidx, page_q[5:0]};
                if (st == StOk && r_item.opcode == OpCreate) begin
                    r_ppc[r_pcount[3:0]] <= pages[6:0];
                    r_clr     <= '0;
                    r_clr_act <= 1'b1;
                end
            end
            // clear page table of new process, one page per cycle
            if (r_clr_act) begin
                r_present[{r_pcount[3:0], r_clr[5:0]}] <= 1'b0;
                r_clr <= r_clr + 7'd1;
                if (r_clr == 7'd63) r_clr_act <= 1'b0;
            end
            if (i_cmd.lookup) begin
                r_hit    <= r_present[r_slot];
                r_scan   <= '0;
                r_best   <= '0;
                r_free   <= 1'b0;
                r_sdone  <= 1'b0;
                r_rd_end <= 1'b0;
            end
            // frame scan: load time is read in the cycle before its compare
            r_tq_v <= scan_rd;
            if (scan_rd) begin
                r_tq_idx  <= si;
                r_tq_last <= (r_scan + 7'd1 >= nfr);
                r_scan    <= r_scan + 7'd1;
                if (r_scan + 7'd1 >= nfr) r_rd_end <= 1'b1;
            end
            // first free frame wins, else oldest with lowest index on ties
            if (scan_free) begin
                r_best  <= si;
                r_free  <= 1'b1;
                r_sdone <= 1'b1;
            end else if (r_tq_v) begin
                if (r_tq_idx == 6'd0 || r_tq < r_best_time) begin
                    r_best      <= r_tq_idx;
                    r_best_time <= r_tq;
                end
                if (r_tq_last) r_sdone <= 1'b1;
            end
            if (i_cmd.commit) begin
                if (r_item.opcode == OpCreate && r_status == StOk)
                    r_pcount <= r_pcount + 5'd1;
                if (frame_wr) begin
                    if (!r_free) r_present[r_victim] <= 1'b0;
                    r_present[r_slot] <= 1'b1;
                    r_occ[r_best]     <= 1'b1;
                end
            end
        end
    end

    // frame owner and load time memories
    always_ff @(posedge i_clk) begin
        if (scan_rd) r_tq <= r_ltime[si];
        r_victim <= r_owner[r_best];
        if (frame_wr) begin
            r_owner[r_best] <= r_slot;
            r_ltime[r_best] <= r_item.time_now;
        end
    end
    assign o_sts.clr_done  = !r_clr_act && (r_clr == 7'd64);
    assign o_sts.hit       = r_hit && !i_cmd.lookup;
    assign o_sts.scan_done = r_sdone;

    // offset = va - page*ps, result address
    logic [5:0]  fr;
    logic [17:0] off;
    logic [31:0] phys;
    logic [30:0] pq_ps;
    assign fr    = r_hit ? r_lk_frame : r_best;
    assign pq_ps = page_q * ps_eff;
    assign off   = r_item.virtual_address - pq_ps[17:0];
    assign phys  = {13'd0, fr} * {6'd0, ps_eff} + {1'b0, off};

    t_out r_out;
    t_out n_out;
    always_comb begin
        n_out = '0;
        n_out.status = r_status;
        if (r_item.opcode == OpCreate) begin
            if (r_status == StOk) n_out.new_process_id = r_pcount + 5'd1;
        end else if (r_status == StOk) begin
            n_out.physical_address = phys[17:0];
            n_out.page_fault       = !r_hit;
            n_out.frame_index      = fr;
            n_out.evicted          = !r_hit && !r_free;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) r_out <= n_out;
    end
    assign o_out = r_out;

    a_clr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_act |-> r_clr < 7'd64) else $error("clear overrun");
    a_pcount: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pcount <= 5'd16) else $error("process count overflow");
    a_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_rd |-> r_scan < 7'd64) else $error("scan overrun");
endmodule
`default_nettype wire

// ----- rtl/core/paged_translation_fifo_replace.sv -----
`default_nettype none
// Demand-paging translator with FIFO frame replacement. One item is taken at a
// time and every item starts with a 19-step restoring divider (page count or
// page/offset split) before the checks. An accepted create then clears its
// 64-entry page table one page per cycle; a rejected item of either kind goes
// straight to the result, and a translate hit does so after its page lookup.
// A translate miss scans the frame table one frame per cycle for the lowest
// free or oldest frame, up to frame_count frames when every frame is in use.
// A finished item waits while a stalled output still holds the last result.
// Configuration writes are accepted any time and belong between items only.
module paged_translation_fifo_replace
    import ptfr_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire        i_cfg_index,
    input  wire [12:0] i_cfg_data,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire  t_in  i_in_data,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out       o_out_data
);
    t_cmd cmd;
    t_sts sts;
    assign o_cfg_ready = 1'b1;

    ptfr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    ptfr_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .i_in(i_in_data), .i_cmd(cmd), .o_sts(sts), .o_out(o_out_data)
    );
endmodule
`default_nettype wire

// ----- verif/paged_translation_fifo_replace_checker.sv -----
`default_nettype none
module paged_translation_fifo_replace_checker
    import ptfr_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_valid,
    input  wire        i_cfg_ready,
    input  wire        i_cfg_index,
    input  wire [12:0] i_cfg_data,
    input  wire        i_in_valid,
    input  wire        i_in_ready,
    input  wire t_in   i_in_data,
    input  wire        i_out_valid,
    input  wire        i_out_ready,
    input  wire t_out  i_out_data,
    output int         o_errors,
    output int         o_pending
);
    // translator state mirror
    logic [12:0] page_size_reg;
    logic [6:0]  frame_count_reg;
    int unsigned proc_total;
    int unsigned proc_pages [MaxProcesses];
    bit          present    [MaxProcesses*MaxPages];
    int unsigned slot_frame [MaxProcesses*MaxPages];
    bit          frame_busy [Frames];
    int unsigned frame_slot [Frames];
    logic [31:0] frame_stamp[Frames];

    t_out expected_results[$];

    task automatic note_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
        $display("mismatch on %s: got %0d expected %0d at %0t", field, got, want, $time);
        o_errors++;
    endtask

    // frame choice: lowest free, else oldest stamp with lowest index on ties
    function automatic int unsigned choose_frame(output bit victim);
        int unsigned n;
        int unsigned best;
        n = (frame_count_reg == 0) ? 1 : (frame_count_reg > Frames) ? Frames
                                                                    : frame_count_reg;
        best = 0;
        for (int i = 0; i < n; i++) begin
            if (!frame_busy[i]) begin
                victim = 0;
                return i;
            end
        end
        for (int i = 1; i < n; i++) begin
            if (frame_stamp[i] < frame_stamp[best]) best = i;
        end
        victim = 1;
        return best;
    endfunction

    // compute one result and advance the mirrored state
    function automatic t_out translate_item(input t_in it);
        t_out r;
        int unsigned ps;
        int unsigned pages;
        int unsigned page;
        int unsigned offs;
        int unsigned slot;
        int unsigned fr;
        bit victim;
        r = '0;
        ps = (page_size_reg == 0) ? 1 : page_size_reg;
        if (it.opcode == OpCreate) begin
            pages = (int'(it.process_size) + ps - 1) / ps;
            if (proc_total >= MaxProcesses) r.status = StFull;
            else if (it.process_size == 0) r.status = StRange;
            else if (pages > MaxPages) r.status = StFull;
            else begin
                proc_pages[proc_total] = pages;
                for (int i = 0; i < MaxPages; i++) present[proc_total*MaxPages + i] = 0;
                proc_total++;
                r.new_process_id = 5'(proc_total);
            end
        end else begin
            page = it.virtual_address / ps;
            offs = it.virtual_address % ps;
            if (it.process_id == 0 || it.process_id > proc_total) r.status = StUnknown;
            else if (page >= proc_pages[it.process_id - 1]) r.status = StRange;
            else begin
                slot = (it.process_id - 1) * MaxPages + page;
                if (present[slot]) fr = slot_frame[slot];
                else begin
                    fr = choose_frame(victim);
                    if (victim && frame_busy[fr]) begin
                        present[frame_slot[fr]] = 0;
                        r.evicted = 1;
                    end
                    frame_busy[fr] = 1;
                    frame_slot[fr] = slot;
                    frame_stamp[fr] = it.time_now;
                    present[slot] = 1;
                    slot_frame[slot] = fr;
                    r.page_fault = 1;
                end
                r.physical_address = 18'(fr * ps + offs);
                r.frame_index = 6'(fr);
            end
        end
        return r;
    endfunction

    // watch all three channels
    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            page_size_reg = 13'd256;
            frame_count_reg = 7'd64;
            proc_total = 0;
            foreach (present[i]) present[i] = 0;
            foreach (frame_busy[i]) begin
                frame_busy[i] = 0;
                frame_stamp[i] = '0;
            end
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $display("unexpected result transfer at %0t", $time);
                    o_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_data.status != want.status)
                        note_mismatch("status", i_out_data.status, want.status);
                    if (i_out_data.physical_address != want.physical_address)
                        note_mismatch("physical_address", i_out_data.physical_address,
                                      want.physical_address);
                    if (i_out_data.page_fault != want.page_fault)
                        note_mismatch("page_fault", i_out_data.page_fault, want.page_fault);
                    if (i_out_data.frame_index != want.frame_index)
                        note_mismatch("frame_index", i_out_data.frame_index,
                                      want.frame_index);
                    if (i_out_data.evicted != want.evicted)
                        note_mismatch("evicted", i_out_data.evicted, want.evicted);
                    if (i_out_data.new_process_id != want.new_process_id)
                        note_mismatch("new_process_id", i_out_data.new_process_id,
                                      want.new_process_id);
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(translate_item(i_in_data));
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CfgPageSize) page_size_reg = i_cfg_data;
                else frame_count_reg = i_cfg_data[6:0];
            end
        end
        o_pending = expected_results.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end
endmodule
`default_nettype wire

// ----- verif/paged_translation_fifo_replace_tb.sv -----
`default_nettype none
module paged_translation_fifo_replace_tb;
    import ptfr_pkg::*;

    localparam int CycleLimit = 800000;
    localparam int PhaseCount = 10;
    localparam int PhaseItems = 63;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_valid = 0;
    logic        cfg_ready;
    logic        cfg_index = 0;
    logic [12:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_ready;
    t_in         in_data = '0;
    logic        out_valid;
    logic        out_ready = 0;
    t_out        out_data;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          stall_left = 0;
    bit          calm = 0;
    logic [31:0] clock_stamp = 0;
    int unsigned eff_ps = 256;

    // register settings per random phase
    logic [12:0] phase_ps [PhaseCount] = '{256, 4096, 1, 0, 100, 8191, 37, 512, 3000, 256};
    logic [12:0] phase_fc [PhaseCount] = '{64, 64, 1, 0, 5, 127, 3, 64, 2, 16};

    paged_translation_fifo_replace DUT (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    paged_translation_fifo_replace_checker checker_u (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // run limit
    always @(posedge clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("paged_translation_fifo_replace test failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side back-pressure
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_ready <= 0;
            stall_left <= stall_left - 1;
        end else if (calm) begin
            out_ready <= 1;
        end else begin
            stall_left <= pick_gap();
            out_ready <= 1;
        end
    end

    task automatic send_item(input t_in it);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [12:0] value);
        @(negedge clk);
        in_valid <= 0;
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 0;
        if (idx == CfgPageSize) eff_ps = (value == 0) ? 1 : value;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic t_in make_create(input logic [18:0] size);
        t_in it;
        it = '0;
        it.opcode = OpCreate;
        it.process_id = 5'($urandom);
        it.virtual_address = 18'($urandom);
        it.process_size = size;
        it.time_now = $urandom;
        return it;
    endfunction

    function automatic t_in make_translate(input logic [4:0] pid, input logic [17:0] va,
                                           input logic [31:0] stamp);
        t_in it;
        it = '0;
        it.opcode = OpTranslate;
        it.process_id = pid;
        it.virtual_address = va;
        it.process_size = 19'($urandom);
        it.time_now = stamp;
        return it;
    endfunction

    // random item: mostly valid accesses into existing processes
    function automatic t_in random_item();
        int r;
        logic [4:0] pid;
        logic [17:0] va;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            if ($urandom_range(0, 3) == 0) return make_create(19'($urandom));
            return make_create(19'($urandom_range(1, eff_ps * 64)));
        end
        clock_stamp = clock_stamp + $urandom_range(0, 3);
        pid = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(1, 16));
        if ($urandom_range(0, 9) == 0) va = 18'($urandom);
        else va = 18'($urandom_range(0, eff_ps * 66 - 1));
        if ($urandom_range(0, 19) == 0)
            return make_translate(pid, va, $urandom);
        return make_translate(pid, va, clock_stamp);
    endfunction

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed corner items at reset settings
        calm = 1;
        send_item(make_create(19'd0));
        send_item(make_create(19'd1));
        send_item(make_create(19'd16384));
        send_item(make_create(19'd16385));
        send_item(make_create(19'h7ffff));
        send_item(make_translate(5'd0, 18'd0, 32'd0));
        send_item(make_translate(5'd31, 18'd0, 32'd0));
        send_item(make_translate(5'd3, 18'd5, 32'd1));
        send_item(make_translate(5'd1, 18'd0, 32'd0));
        send_item(make_translate(5'd1, 18'd0, 32'd9));
        send_item(make_translate(5'd1, 18'd256, 32'd2));
        send_item(make_translate(5'd2, 18'd16383, 32'hffffffff));
        send_item(make_translate(5'd2, 18'd16384, 32'd3));
        send_item(make_translate(5'd2, 18'h3ffff, 32'd3));
        send_item(make_translate(5'd2, 18'd300, 32'd0));
        send_item(make_create(19'd700));
        send_item(make_translate(5'd3, 18'd767, 32'd4));
        wait_drained();

        // random phases across register settings
        for (int p = 0; p < PhaseCount; p++) begin
            write_reg(CfgPageSize, phase_ps[p]);
            write_reg(CfgFrameCount, phase_fc[p]);
            calm = (p == 3);
            for (int k = 0; k < PhaseItems; k++) begin
                // sender holds off until the block is fully drained
                if (p == 4 && k == 30) wait_drained();
                send_item(random_item());
            end
            wait_drained();
        end

        if (errors == 0) begin
            $display("paged_translation_fifo_replace test passed");
        end else begin
            $display("paged_translation_fifo_replace test failed");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/core/ptfr_pkg.sv
rtl/core/ptfr_ctrl.sv
rtl/core/ptfr_dp.sv
rtl/core/paged_translation_fifo_replace.sv
verif/paged_translation_fifo_replace_checker.sv
verif/paged_translation_fifo_replace_tb.sv
